[sv/tsbc_pkg.sv]
// shared types and constants for the token stream body counter
// no dependencies
`timescale 1ns / 1ps

package tsbc_pkg;

    localparam int BYTE_W         = 8;
    localparam int CODE_W         = 13;
    localparam int COUNT_W        = 17;
    localparam int SKIP_W         = 24;
    localparam int OP_HIGH_W      = 5;
    localparam int LEN_LEFT_W     = 2;
    localparam int CFG_IDX_W      = 1;
    localparam int CFG_DATA_W     = CODE_W;

    localparam int HEADER_LIMIT_DEF = 256;
    localparam int DEPTH_BITS_DEF   = 8;

    localparam logic [CFG_IDX_W-1:0] CFG_BEGIN_BODY = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_END_BODY   = 1'd1;

    localparam logic [CODE_W-1:0] BEGIN_BODY_RST = 13'd106;
    localparam logic [CODE_W-1:0] END_BODY_RST   = 13'd107;

    localparam logic [COUNT_W-1:0] TOTAL_MAX = 17'h10000;

    localparam logic [BYTE_W-1:0] CHAR_SPACE = 8'h20;

    localparam logic [2:0] CLS_LONG_OP = 3'b101;
    localparam logic [2:0] CLS_SEQ1    = 3'b110;
    localparam logic [2:0] CLS_SEQ3    = 3'b111;

    localparam logic [LEN_LEFT_W-1:0] LEN1_BYTES = 2'd1;
    localparam logic [LEN_LEFT_W-1:0] LEN3_BYTES = 2'd3;

    typedef enum logic [2:0] {
        PH_HEADER = 3'd0,
        PH_TOKEN  = 3'd1,
        PH_NUM2   = 3'd2,
        PH_OP2    = 3'd3,
        PH_LEN    = 3'd4,
        PH_SKIP   = 3'd5
    } t_phase;

    typedef struct packed {
        logic [BYTE_W-1:0] data_byte;
        logic              end_of_stream;
    } t_word;

    typedef struct packed {
        logic signed [COUNT_W-1:0] page_count;
        logic                      stream_error;
    } t_result;

endpackage

[sv/tsbc_in_if.sv]
// input byte channel: valid, ready and one byte with its last-word flag
// depends on tsbc_pkg
`timescale 1ns / 1ps

interface tsbc_in_if import tsbc_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [BYTE_W-1:0] data_byte;
    logic              end_of_stream;

    modport source (output valid, output data_byte, output end_of_stream, input ready);
    modport sink   (input valid, input data_byte, input end_of_stream, output ready);
endinterface

[sv/tsbc_out_if.sv]
// result channel: valid, ready, page count and error flag
// depends on tsbc_pkg
`timescale 1ns / 1ps

interface tsbc_out_if import tsbc_pkg::*; ();
    logic                      valid;
    logic                      ready;
    logic signed [COUNT_W-1:0] page_count;
    logic                      stream_error;

    modport source (output valid, output page_count, output stream_error, input ready);
    modport sink   (input valid, input page_count, input stream_error, output ready);
endinterface

[sv/tsbc_parser.sv]
// header skip, token parse state and body nesting counter, one byte per step
// depends on tsbc_pkg
`timescale 1ns / 1ps

module tsbc_parser import tsbc_pkg::*; #(
    parameter int HEADER_LIMIT = HEADER_LIMIT_DEF,
    parameter int DEPTH_BITS   = DEPTH_BITS_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_step,
    input  t_word             i_word,
    input  logic [CODE_W-1:0] i_begin_code,
    input  logic [CODE_W-1:0] i_end_code,
    output t_result           o_result,
    output t_phase            o_phase
);

    localparam int HDR_W = $clog2(HEADER_LIMIT + 1);

    t_phase                  r_phase,    n_phase;
    logic [HDR_W-1:0]        r_hdr_cnt,  n_hdr_cnt;
    logic [LEN_LEFT_W-1:0]   r_len_left, n_len_left;
    logic [OP_HIGH_W-1:0]    r_op_high,  n_op_high;
    logic [SKIP_W-1:0]       r_skip,     n_skip;
    logic [DEPTH_BITS-1:0]   r_depth,    n_depth;
    logic [COUNT_W-1:0]      r_total,    n_total;

    logic [BYTE_W-1:0]       b;
    logic [CODE_W-1:0]       op_code;

    assign b       = i_word.data_byte;
    assign op_code = {r_op_high, b};

    always_comb begin
        n_phase    = r_phase;
        n_hdr_cnt  = r_hdr_cnt;
        n_len_left = r_len_left;
        n_op_high  = r_op_high;
        n_skip     = r_skip;
        n_depth    = r_depth;
        n_total    = r_total;
        case (r_phase)
            PH_HEADER: begin
                n_hdr_cnt = r_hdr_cnt + 1'b1;
                if (b == CHAR_SPACE || n_hdr_cnt >= HDR_W'(HEADER_LIMIT)) begin
                    n_phase = PH_TOKEN;
                end
            end
            PH_TOKEN: begin
                if (!b[7]) begin
                    n_phase = PH_NUM2;
                end else begin
                    case (b[7:5])
                        CLS_LONG_OP: begin
                            n_op_high = b[OP_HIGH_W-1:0];
                            n_phase   = PH_OP2;
                        end
                        CLS_SEQ1: begin
                            n_skip     = '0;
                            n_len_left = LEN1_BYTES;
                            n_phase    = PH_LEN;
                        end
                        CLS_SEQ3: begin
                            n_skip     = '0;
                            n_len_left = LEN3_BYTES;
                            n_phase    = PH_LEN;
                        end
                        default: begin
                        end
                    endcase
                end
            end
            PH_NUM2: begin
                n_phase = PH_TOKEN;
            end
            PH_OP2: begin
                if (op_code == i_begin_code) begin
                    n_depth = r_depth + 1'b1;
                end else if (op_code == i_end_code) begin
                    n_depth = r_depth - 1'b1;
                    if (n_depth == '0 && r_total < TOTAL_MAX) begin
                        n_total = r_total + 1'b1;
                    end
                end
                n_phase = PH_TOKEN;
            end
            PH_LEN: begin
                n_skip     = {r_skip[SKIP_W-BYTE_W-1:0], b};
                n_len_left = r_len_left - 1'b1;
                if (n_len_left == '0) begin
                    n_phase = (n_skip != '0) ? PH_SKIP : PH_TOKEN;
                end
            end
            PH_SKIP: begin
                n_skip = r_skip - 1'b1;
                if (n_skip == '0) begin
                    n_phase = PH_TOKEN;
                end
            end
            default: begin
                n_phase = PH_TOKEN;
            end
        endcase
    end

    always_comb begin
        if (n_phase == PH_TOKEN) begin
            o_result.page_count   = n_total - 1'b1;
            o_result.stream_error = 1'b0;
        end else begin
            o_result.page_count   = '1;
            o_result.stream_error = 1'b1;
        end
    end

    assign o_phase = r_phase;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || (i_step && i_word.end_of_stream)) begin
            r_phase    <= PH_HEADER;
            r_hdr_cnt  <= '0;
            r_len_left <= '0;
            r_op_high  <= '0;
            r_skip     <= '0;
            r_depth    <= '0;
            r_total    <= '0;
        end else if (i_step) begin
            r_phase    <= n_phase;
            r_hdr_cnt  <= n_hdr_cnt;
            r_len_left <= n_len_left;
            r_op_high  <= n_op_high;
            r_skip     <= n_skip;
            r_depth    <= n_depth;
            r_total    <= n_total;
        end
    end

endmodule

[sv/token_stream_body_counter.sv]
// token stream body counter top level: input register, parser, result register
// depends on tsbc_pkg, tsbc_in_if, tsbc_out_if and tsbc_parser
// result: registered from the parser when its last word leaves the input register
// throughput: one word per cycle while no last word is stalled, limited by the single parser step per cycle
// stalls: a last word waits in the input register while a result is still unaccepted
// reset: synchronous active low; parser back in header phase, codes 106 and 107
`timescale 1ns / 1ps

module token_stream_body_counter import tsbc_pkg::*; #(
    parameter int HEADER_LIMIT = HEADER_LIMIT_DEF,
    parameter int DEPTH_BITS   = DEPTH_BITS_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    tsbc_in_if.sink               i_in,
    tsbc_out_if.source            o_out,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    logic              cfg_begin_sel;
    logic [CODE_W-1:0] r_begin_body;
    logic [CODE_W-1:0] r_end_body;

    logic              r_in_valid;
    t_word             r_in_word;
    logic              r_out_valid;
    t_result           r_out;

    logic              out_free;
    logic              step;
    logic              in_take;
    t_result           res;
    t_phase            phase;

    assign cfg_begin_sel = (i_cfg_index == CFG_BEGIN_BODY);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_begin_body <= BEGIN_BODY_RST;
            r_end_body   <= END_BODY_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_BEGIN_BODY: r_begin_body <= i_cfg_data;
                CFG_END_BODY:   r_end_body   <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    assign out_free   = !r_out_valid || o_out.ready;
    assign step       = r_in_valid && (!r_in_word.end_of_stream || out_free);
    assign i_in.ready = !r_in_valid || step;
    assign in_take    = i_in.valid && i_in.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_in.ready) begin
            r_in_valid <= i_in.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_in_word.data_byte     <= i_in.data_byte;
            r_in_word.end_of_stream <= i_in.end_of_stream;
        end
    end

    tsbc_parser #(
        .HEADER_LIMIT (HEADER_LIMIT),
        .DEPTH_BITS   (DEPTH_BITS)
    ) u_parser (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_step       (step),
        .i_word       (r_in_word),
        .i_begin_code (r_begin_body),
        .i_end_code   (r_end_body),
        .o_result     (res),
        .o_phase      (phase)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (step && r_in_word.end_of_stream) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (step && r_in_word.end_of_stream) begin
            r_out <= res;
        end
    end

    assign o_out.valid        = r_out_valid;
    assign o_out.page_count   = r_out.page_count;
    assign o_out.stream_error = r_out.stream_error;

    a_err_all_ones: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_out.stream_error |-> r_out.page_count == '1)
        else $error("error result without all-ones count");

    a_empty_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_in_valid |-> i_in.ready)
        else $error("empty input register not ready");

    a_last_resets: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        step && r_in_word.end_of_stream |=> phase == PH_HEADER && r_out_valid)
        else $error("last word did not restart parse or post result");

    a_cfg_idle_sel: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cfg_we && cfg_begin_sel |=> r_begin_body == $past(i_cfg_data))
        else $error("begin code write lost");

endmodule

[tb/tb_token_stream_body_counter.sv]
// self-checking testbench for token_stream_body_counter: byte files are built here,
// sent one word at a time, and each page count is checked against an in-bench parser
// depends on tsbc_pkg, tsbc_in_if, tsbc_out_if and the token_stream_body_counter rtl
`timescale 1ns / 1ps

module tb_token_stream_body_counter;
    import tsbc_pkg::*;

    localparam int         WATCHDOG_LIMIT = 2000;
    localparam int         SHOW_LIMIT     = 10;
    localparam logic [2:0] CLS_SHORT_OP   = 3'b100;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n;
    logic                  i_cfg_we;
    logic [CFG_IDX_W-1:0]  i_cfg_index;
    logic [CFG_DATA_W-1:0] i_cfg_data;

    tsbc_in_if  in_ch ();
    tsbc_out_if out_ch ();

    token_stream_body_counter dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in        (in_ch),
        .o_out       (out_ch),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    always #5 i_clk = ~i_clk;

    // parser state mirrored in the bench
    t_phase              m_phase;
    logic [8:0]          m_hdr_seen;
    logic [LEN_LEFT_W-1:0] m_len_left;
    logic [OP_HIGH_W-1:0]  m_op_high;
    logic [SKIP_W-1:0]   m_skip_left;
    logic [7:0]          m_depth;
    logic [COUNT_W-1:0]  m_bodies;
    logic [CODE_W-1:0]   m_open_code;
    logic [CODE_W-1:0]   m_close_code;

    t_result     page_results_due[$];
    logic [7:0]  file_buf[$];

    bit          idle_en;
    int unsigned ready_hold;
    int          words_sent;
    int          files_sent;
    int          counts_checked;
    int          errors;
    int          quiet_cycles;

    function automatic void clear_parse();
        m_phase     = PH_HEADER;
        m_hdr_seen  = '0;
        m_len_left  = '0;
        m_op_high   = '0;
        m_skip_left = '0;
        m_depth     = '0;
        m_bodies    = '0;
    endfunction

    function automatic void count_long_op(logic [CODE_W-1:0] code);
        if (code == m_open_code) begin
            m_depth = m_depth + 8'd1;
        end else if (code == m_close_code) begin
            m_depth = m_depth - 8'd1;
            if (m_depth == 8'd0 && m_bodies < TOTAL_MAX) begin
                m_bodies = m_bodies + 17'd1;
            end
        end
    endfunction

    function automatic void parse_byte(logic [7:0] b, logic last);
        t_result res;
        case (m_phase)
            PH_HEADER: begin
                m_hdr_seen = m_hdr_seen + 9'd1;
                if (b == CHAR_SPACE || m_hdr_seen >= HEADER_LIMIT_DEF) m_phase = PH_TOKEN;
            end
            PH_TOKEN: begin
                if (!b[7]) begin
                    m_phase = PH_NUM2;
                end else begin
                    case (b[7:5])
                        CLS_LONG_OP: begin
                            m_op_high = b[4:0];
                            m_phase   = PH_OP2;
                        end
                        CLS_SEQ1: begin
                            m_skip_left = '0;
                            m_len_left  = LEN1_BYTES;
                            m_phase     = PH_LEN;
                        end
                        CLS_SEQ3: begin
                            m_skip_left = '0;
                            m_len_left  = LEN3_BYTES;
                            m_phase     = PH_LEN;
                        end
                        default: ;
                    endcase
                end
            end
            PH_NUM2: m_phase = PH_TOKEN;
            PH_OP2: begin
                count_long_op({m_op_high, b});
                m_phase = PH_TOKEN;
            end
            PH_LEN: begin
                m_skip_left = {m_skip_left[15:0], b};
                m_len_left  = m_len_left - 2'd1;
                if (m_len_left == '0) m_phase = (m_skip_left != '0) ? PH_SKIP : PH_TOKEN;
            end
            PH_SKIP: begin
                m_skip_left = m_skip_left - 24'd1;
                if (m_skip_left == '0) m_phase = PH_TOKEN;
            end
            default: m_phase = PH_TOKEN;
        endcase
        if (last) begin
            if (m_phase == PH_TOKEN) begin
                res.page_count   = m_bodies - 17'd1;
                res.stream_error = 1'b0;
            end else begin
                res.page_count   = '1;
                res.stream_error = 1'b1;
            end
            page_results_due.push_back(res);
            clear_parse();
        end
    endfunction

    function automatic void report_fault(string msg);
        errors++;
        if (errors <= SHOW_LIMIT) $display("mismatch at %0t: %s", $realtime, msg);
    endfunction

    // result side: random stalls, checking and the watchdog
    always @(posedge i_clk) begin
        if (!idle_en) begin
            out_ch.ready <= 1'b1;
        end else if (ready_hold != 0) begin
            ready_hold--;
            out_ch.ready <= 1'b0;
        end else if ($urandom_range(0, 5) == 0) begin
            ready_hold = $urandom_range(0, 7);
            out_ch.ready <= 1'b0;
        end else begin
            out_ch.ready <= 1'b1;
        end
    end

    always @(posedge i_clk) begin
        t_result want;
        if (i_rst_n) begin
            if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
                quiet_cycles = 0;
            end else begin
                quiet_cycles++;
            end
            if (quiet_cycles >= WATCHDOG_LIMIT) begin
                $display("watchdog: nothing moved for %0d cycles, %0d counts still due",
                         quiet_cycles, page_results_due.size());
                $display("Testbench completed WITH ERRORS");
                $finish;
            end else if (out_ch.valid && out_ch.ready) begin
                counts_checked++;
                if (page_results_due.size() == 0) begin
                    report_fault($sformatf("unexpected result page_count %0d stream_error %0b",
                                           $signed(out_ch.page_count), out_ch.stream_error));
                end else begin
                    want = page_results_due.pop_front();
                    if (out_ch.page_count !== want.page_count ||
                        out_ch.stream_error !== want.stream_error) begin
                        report_fault($sformatf(
                            "page_count exp %0d got %0d, stream_error exp %0b got %0b",
                            $signed(want.page_count), $signed(out_ch.page_count),
                            want.stream_error, out_ch.stream_error));
                    end
                end
            end
        end
    end

    task automatic send_word(input logic [7:0] b, input logic last);
        if (idle_en && $urandom_range(0, 5) == 0) begin
            in_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge i_clk);
        end
        in_ch.valid         <= 1'b1;
        in_ch.data_byte     <= b;
        in_ch.end_of_stream <= last;
        @(posedge i_clk);
        while (!in_ch.ready) @(posedge i_clk);
        parse_byte(b, last);
        words_sent++;
    endtask

    task automatic send_file(input int cut);
        for (int i = 0; i <= cut; i++) send_word(file_buf[i], i == cut);
        files_sent++;
    endtask

    task automatic settle();
        in_ch.valid <= 1'b0;
        while (page_results_due.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic set_body_codes(input logic [CODE_W-1:0] open_code,
                                  input logic [CODE_W-1:0] close_code);
        settle();
        i_cfg_we    <= 1'b1;
        i_cfg_index <= CFG_BEGIN_BODY;
        i_cfg_data  <= open_code;
        @(posedge i_clk);
        i_cfg_index <= CFG_END_BODY;
        i_cfg_data  <= close_code;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        m_open_code  = open_code;
        m_close_code = close_code;
    endtask

    function automatic logic [7:0] any_but_space();
        logic [7:0] b;
        b = 8'($urandom);
        if (b == CHAR_SPACE) b = 8'h21;
        return b;
    endfunction

    function automatic void add_header(int len, bit with_space);
        for (int i = 0; i < len; i++) file_buf.push_back(any_but_space());
        if (with_space) file_buf.push_back(CHAR_SPACE);
    endfunction

    function automatic void add_long_op(logic [CODE_W-1:0] code);
        file_buf.push_back({CLS_LONG_OP, code[12:8]});
        file_buf.push_back(code[7:0]);
    endfunction

    function automatic void add_seq(bit wide, logic [SKIP_W-1:0] len);
        file_buf.push_back({wide ? CLS_SEQ3 : CLS_SEQ1, 5'($urandom)});
        if (wide) begin
            file_buf.push_back(len[23:16]);
            file_buf.push_back(len[15:8]);
        end
        file_buf.push_back(len[7:0]);
        for (int i = 0; i < int'(len); i++) file_buf.push_back(8'($urandom));
    endfunction

    function automatic void build_random_file();
        int open_cnt;
        file_buf.delete();
        add_header($urandom_range(0, 6), 1'b1);
        // noise after the header
        if ($urandom_range(0, 9) == 0) begin
            repeat ($urandom_range(1, 20)) file_buf.push_back(8'($urandom));
            return;
        end
        open_cnt = 0;
        repeat ($urandom_range(1, 10)) begin
            case ($urandom_range(0, 11))
                0, 1, 2: begin
                    add_long_op(m_open_code);
                    open_cnt++;
                end
                3, 4, 5: begin
                    add_long_op(m_close_code);
                    open_cnt--;
                end
                6: begin
                    file_buf.push_back({1'b0, 7'($urandom)});
                    file_buf.push_back(8'($urandom));
                end
                8: add_long_op(13'($urandom));
                9: add_seq(1'b0, 24'($urandom_range(0, 6)));
                10: add_seq(1'b1, ($urandom_range(0, 15) == 0) ? 24'($urandom_range(256, 300))
                                                              : 24'($urandom_range(0, 6)));
                default: file_buf.push_back({CLS_SHORT_OP, 5'($urandom)});
            endcase
        end
        while (open_cnt > 0 && $urandom_range(0, 4) != 0) begin
            add_long_op(m_close_code);
            open_cnt--;
        end
    endfunction

    task automatic test_directed_cases();
        // header closed by the last word
        file_buf.delete();
        add_header(0, 1'b1);
        send_file(file_buf.size() - 1);
        // header still open at the end
        file_buf.delete();
        add_header(1, 1'b0);
        send_file(file_buf.size() - 1);
        // one body
        file_buf.delete();
        add_header(0, 1'b1);
        add_long_op(m_open_code);
        add_long_op(m_close_code);
        send_file(file_buf.size() - 1);
        // short number missing its second word
        file_buf.delete();
        add_header(0, 1'b1);
        file_buf.push_back(8'h7f);
        send_file(file_buf.size() - 1);
        // empty sequence then a short op
        file_buf.delete();
        add_header(0, 1'b1);
        add_seq(1'b0, '0);
        file_buf.push_back({CLS_SHORT_OP, 5'h1f});
        send_file(file_buf.size() - 1);
        // payload still owed
        file_buf.delete();
        add_header(0, 1'b1);
        add_seq(1'b1, 24'd2);
        send_file(file_buf.size() - 2);
        // missing length word
        file_buf.delete();
        add_header(0, 1'b1);
        add_seq(1'b1, 24'd0);
        send_file(1);
        // extreme words and the top long-op code
        file_buf.delete();
        add_header(0, 1'b1);
        file_buf.push_back(8'h00);
        file_buf.push_back(8'hff);
        add_long_op(13'h1fff);
        send_file(file_buf.size() - 1);
        // long op cut after its first word
        send_file(file_buf.size() - 2);
    endtask

    task automatic test_header_limit();
        // header ends at the byte limit, then one body
        file_buf.delete();
        add_header(HEADER_LIMIT_DEF, 1'b0);
        add_long_op(m_open_code);
        add_long_op(m_close_code);
        send_file(file_buf.size() - 1);
    endtask

    task automatic test_depth_wrap();
        // close from zero wraps below, the next open wraps back past the top
        file_buf.delete();
        add_header(0, 1'b1);
        add_long_op(m_close_code);
        add_long_op(m_open_code);
        add_long_op(m_open_code);
        add_long_op(m_open_code);
        add_long_op(m_close_code);
        add_long_op(m_close_code);
        send_file(file_buf.size() - 1);
    endtask

    task automatic test_equal_codes();
        set_body_codes(13'd500, 13'd500);
        file_buf.delete();
        add_header(2, 1'b1);
        repeat (3) add_long_op(13'd500);
        send_file(file_buf.size() - 1);
    endtask

    task automatic test_random_files(input int word_goal, input int file_goal,
                                     input bit allow_idle);
        int start_words;
        int start_files;
        int cut;
        start_words = words_sent;
        start_files = files_sent;
        while (words_sent - start_words < word_goal || files_sent - start_files < file_goal) begin
            build_random_file();
            cut = ($urandom_range(0, 6) == 0) ? $urandom_range(0, file_buf.size() - 1)
                                              : file_buf.size() - 1;
            idle_en = allow_idle && ($urandom_range(0, 3) != 0);
            send_file(cut);
        end
    endtask

    task automatic test_code_sweep();
        set_body_codes(13'd0, 13'h1fff);
        test_random_files(40, 4, 1'b1);
        set_body_codes(13'h1fff, 13'd0);
        test_random_files(40, 4, 1'b1);
        set_body_codes(13'($urandom), 13'($urandom));
        test_random_files(40, 4, 1'b1);
        set_body_codes(BEGIN_BODY_RST, END_BODY_RST);
    endtask

    initial begin
        i_rst_n             <= 1'b0;
        i_cfg_we            <= 1'b0;
        i_cfg_index         <= CFG_BEGIN_BODY;
        i_cfg_data          <= '0;
        in_ch.valid         <= 1'b0;
        in_ch.data_byte     <= '0;
        in_ch.end_of_stream <= 1'b0;
        clear_parse();
        m_open_code  = BEGIN_BODY_RST;
        m_close_code = END_BODY_RST;
        idle_en      = 1'b1;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_directed_cases();
        test_header_limit();
        test_depth_wrap();
        test_equal_codes();
        test_code_sweep();
        test_random_files(60, 4, 1'b0);
        settle();

        $display("covered %0d words in %0d files, %0d page counts compared",
                 words_sent, files_sent, counts_checked);
        $display("code settings swept: reset, both extremes, random and equal; %0d mismatches",
                 errors);
        if (errors == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule

[files.f]
sv/tsbc_pkg.sv
sv/tsbc_in_if.sv
sv/tsbc_out_if.sv
sv/tsbc_parser.sv
sv/token_stream_body_counter.sv
tb/tb_token_stream_body_counter.sv
